### hdl/pat2d_pkg.sv
package pat2d_pkg;

    // Default widths of the datapath
    localparam int COORD_BITS_DEF      = 16;
    localparam int SCALE_FRAC_BITS_DEF = 8;
    localparam int TRIG_FRAC_BITS_DEF  = 14;

    // Configuration port geometry
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Angle handling
    localparam logic [8:0] ANGLE_FULL   = 9'd360;
    localparam logic [8:0] ANGLE_HALF   = 9'd180;
    localparam logic [8:0] ANGLE_3QTR   = 9'd270;
    localparam logic [8:0] ANGLE_QTR    = 9'd90;
    localparam int         QUARTER_DEG  = 90;

    // Sine table build: fraction bits of the working series and pi at that scale
    localparam int          WORK_FRAC = 30;
    localparam logic [63:0] PI_WORK   = 64'd3373259426;

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_PASS      = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE    = 3'd0,
        CFG_SHIFT_X = 3'd1,
        CFG_SHIFT_Y = 3'd2,
        CFG_SCALE_X = 3'd3,
        CFG_SCALE_Y = 3'd4,
        CFG_ANGLE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef logic [63:0] t_sine_rom [0:QUARTER_DEG];

    // Quarter-wave sine table, sin(d*pi/180) for d = 0..90, by an integer
    // Taylor series at WORK_FRAC bits, rounded half up to frac bits
    function automatic t_sine_rom build_sine_rom(int frac);
        t_sine_rom   rom;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] term;
        longint      sum;
        for (int d = 0; d <= QUARTER_DEG; d++) begin
            r    = (64'(d) * PI_WORK + 64'd90) / 64'd180;
            r2   = (r * r) >> WORK_FRAC;
            term = r;
            sum  = longint'(r);
            term = ((term * r2) >> WORK_FRAC) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd210;
            sum  = sum - longint'(term);
            term = ((term * r2) >> WORK_FRAC) / 64'd272;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            rom[d] = (64'(sum) + (64'd1 << (WORK_FRAC - frac - 1))) >> (WORK_FRAC - frac);
        end
        return rom;
    endfunction

endpackage

### hdl/point_affine_transform_2d_top.sv
// Each vertex passes through four register stages (capture, multiply,
// combine, round/saturate) on its way to the output.
// Throughput: one vertex per cycle while m_axis_tready does not stall the
// output; the four multipliers of the rotate path set the stage depth.
// Each stage refills as soon as its successor moves on.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with mode translate, zero shifts, unit scales and angle 0.
module point_affine_transform_2d_top #(
    parameter int COORD_BITS      = pat2d_pkg::COORD_BITS_DEF,
    parameter int SCALE_FRAC_BITS = pat2d_pkg::SCALE_FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS  = pat2d_pkg::TRIG_FRAC_BITS_DEF,
    parameter int TDATA_BITS      = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration writes
    input  logic                                 i_cfg_we,
    input  logic [pat2d_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [pat2d_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // Vertex in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [TDATA_BITS-1:0]                s_axis_tdata,  // x_in, y_in
    // Vertex out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [TDATA_BITS-1:0]                m_axis_tdata,  // x_out, y_out
    output logic                                 m_axis_tuser   // saturated
);
    import pat2d_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PS = COORD_BITS + CFG_DATA_BITS;
    localparam int PT = COORD_BITS + TW;
    localparam int WA = (PS > PT + 1) ? PS : PT + 1;
    localparam int W  = WA + 1;

    localparam t_sine_rom SINE_ROM = build_sine_rom(TRIG_FRAC_BITS);

    localparam logic signed [W-1:0] HALF_S = {{(W-1){1'b0}}, 1'b1} << (SCALE_FRAC_BITS - 1);
    localparam logic signed [W-1:0] HALF_T = {{(W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

    // Configuration registers
    t_mode                           r_mode;
    logic signed [CFG_DATA_BITS-1:0] r_shift_x;
    logic signed [CFG_DATA_BITS-1:0] r_shift_y;
    logic signed [CFG_DATA_BITS-1:0] r_scale_x;
    logic signed [CFG_DATA_BITS-1:0] r_scale_y;
    logic [8:0]                      r_angle;

    // Sine and cosine of the configured angle
    logic signed [TW-1:0] r_sin;
    logic signed [TW-1:0] r_cos;
    logic signed [TW-1:0] n_sin;
    logic signed [TW-1:0] n_cos;
    logic [8:0]           a_mod;
    logic [6:0]           a_rem;
    t_quad                a_quad;
    logic signed [TW-1:0] t_lo;
    logic signed [TW-1:0] t_hi;

    // Pipeline control
    logic [3:0] r_vld;
    logic [3:0] en;

    // Stage payloads
    logic signed [C-1:0]  r_a_x;
    logic signed [C-1:0]  r_a_y;
    logic signed [W-1:0]  r_b_x0;
    logic signed [W-1:0]  r_b_x1;
    logic signed [W-1:0]  r_b_y0;
    logic signed [W-1:0]  r_b_y1;
    logic signed [W-1:0]  n_b_x0;
    logic signed [W-1:0]  n_b_x1;
    logic signed [W-1:0]  n_b_y0;
    logic signed [W-1:0]  n_b_y1;
    logic signed [W-1:0]  r_c_x;
    logic signed [W-1:0]  r_c_y;
    logic [C-1:0]         r_d_x;
    logic [C-1:0]         r_d_y;
    logic                 r_d_sat;
    logic [C:0]           n_d_x;
    logic [C:0]           n_d_y;

    // Products
    logic signed [PS-1:0] m_xsx;
    logic signed [PS-1:0] m_ysy;
    logic signed [PT-1:0] m_xc;
    logic signed [PT-1:0] m_ys;
    logic signed [PT-1:0] m_xs;
    logic signed [PT-1:0] m_yc;

    // Round to nearest (ties away from zero) in scale and rotate modes, and clamp; returns {hit, value}
    function automatic logic [C:0] round_sat(logic signed [W-1:0] v, t_mode mode);
        logic signed [W-1:0] rnd;
        logic signed [W-1:0] neg_w;
        logic [W-C:0]        top;
        neg_w = {{(W-1){1'b0}}, v[W-1]};
        case (mode)
            MODE_SCALE: begin
                rnd = (v + HALF_S - neg_w) >>> SCALE_FRAC_BITS;
            end
            MODE_ROTATE: begin
                rnd = (v + HALF_T - neg_w) >>> TRIG_FRAC_BITS;
            end
            default: begin
                rnd = v;
            end
        endcase
        top = rnd[W-1:C-1];
        if ((&top) || !(|top)) begin
            return {1'b0, rnd[C-1:0]};
        end
        return {1'b1, rnd[W-1], {(C-1){~rnd[W-1]}}};
    endfunction

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TRANSLATE;
            r_shift_x <= '0;
            r_shift_y <= '0;
            r_scale_x <= 16'sd256;
            r_scale_y <= 16'sd256;
            r_angle   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[1:0]);
                CFG_SHIFT_X: r_shift_x <= i_cfg_data;
                CFG_SHIFT_Y: r_shift_y <= i_cfg_data;
                CFG_SCALE_X: r_scale_x <= i_cfg_data;
                CFG_SCALE_Y: r_scale_y <= i_cfg_data;
                CFG_ANGLE:   r_angle   <= i_cfg_data[8:0];
                default:     ;
            endcase
        end
    end

    // Fold the angle into a quadrant and an offset, look up the table
    always_comb begin
        a_mod = (r_angle >= ANGLE_FULL) ? (r_angle - ANGLE_FULL) : r_angle;
        if (a_mod >= ANGLE_3QTR) begin
            a_quad = QUAD_3;
            a_rem  = 7'(a_mod - ANGLE_3QTR);
        end else if (a_mod >= ANGLE_HALF) begin
            a_quad = QUAD_2;
            a_rem  = 7'(a_mod - ANGLE_HALF);
        end else if (a_mod >= ANGLE_QTR) begin
            a_quad = QUAD_1;
            a_rem  = 7'(a_mod - ANGLE_QTR);
        end else begin
            a_quad = QUAD_0;
            a_rem  = 7'(a_mod);
        end
        t_lo = {1'b0, SINE_ROM[a_rem][TRIG_FRAC_BITS:0]};
        t_hi = {1'b0, SINE_ROM[7'(7'(QUARTER_DEG) - a_rem)][TRIG_FRAC_BITS:0]};
        case (a_quad)
            QUAD_0: begin
                n_sin = t_lo;
                n_cos = t_hi;
            end
            QUAD_1: begin
                n_sin = t_hi;
                n_cos = -t_lo;
            end
            QUAD_2: begin
                n_sin = -t_lo;
                n_cos = -t_hi;
            end
            default: begin
                n_sin = -t_hi;
                n_cos = t_lo;
            end
        endcase
    end

    // Hold the trig values of the current angle
    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    // Each stage loads when it is empty or its successor moves on
    assign en[3] = !r_vld[3] || m_axis_tready;
    assign en[2] = !r_vld[2] || en[3];
    assign en[1] = !r_vld[1] || en[2];
    assign en[0] = !r_vld[0] || en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= s_axis_tvalid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Stage A: capture the vertex
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_x <= s_axis_tdata[C-1:0];
            r_a_y <= s_axis_tdata[2*C-1:C];
        end
    end

    // Stage B: multiply, add or pass through by mode
    assign m_xsx = r_a_x * r_scale_x;
    assign m_ysy = r_a_y * r_scale_y;
    assign m_xc  = r_a_x * r_cos;
    assign m_ys  = r_a_y * r_sin;
    assign m_xs  = r_a_x * r_sin;
    assign m_yc  = r_a_y * r_cos;

    always_comb begin
        n_b_x1 = '0;
        n_b_y1 = '0;
        case (r_mode)
            MODE_TRANSLATE: begin
                n_b_x0 = W'(r_a_x) + W'(r_shift_x);
                n_b_y0 = W'(r_a_y) + W'(r_shift_y);
            end
            MODE_SCALE: begin
                n_b_x0 = W'(m_xsx);
                n_b_y0 = W'(m_ysy);
            end
            MODE_ROTATE: begin
                n_b_x0 = W'(m_xc);
                n_b_x1 = W'(m_ys);
                n_b_y0 = W'(m_xs);
                n_b_y1 = W'(m_yc);
            end
            default: begin
                n_b_x0 = W'(r_a_x);
                n_b_y0 = W'(r_a_y);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_x0 <= n_b_x0;
            r_b_x1 <= n_b_x1;
            r_b_y0 <= n_b_y0;
            r_b_y1 <= n_b_y1;
        end
    end

    // Stage C: combine the partial terms
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_x <= r_b_x0 - r_b_x1;
            r_c_y <= r_b_y0 + r_b_y1;
        end
    end

    // Stage D: round, clamp and flag
    assign n_d_x = round_sat(r_c_x, r_mode);
    assign n_d_y = round_sat(r_c_y, r_mode);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_d_x   <= n_d_x[C-1:0];
            r_d_y   <= n_d_y[C-1:0];
            r_d_sat <= n_d_x[C] | n_d_y[C];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[3];
    assign m_axis_tdata  = TDATA_BITS'({r_d_y, r_d_x});
    assign m_axis_tuser  = r_d_sat;

    // An empty output stage never stalls the input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[3] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // A flagged result sits on a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (r_d_x == {1'b0, {(C-1){1'b1}}}) || (r_d_x == {1'b1, {(C-1){1'b0}}}) ||
            (r_d_y == {1'b0, {(C-1){1'b1}}}) || (r_d_y == {1'b1, {(C-1){1'b0}}}))
        else $error("saturation flag without clamped coordinate");

    // Pass-through never clamps
    a_pass_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_mode == MODE_PASS)) |-> !m_axis_tuser)
        else $error("saturation flagged in pass-through mode");

endmodule

### tb/sv/tb_point_affine_transform_2d_top.sv
module tb_point_affine_transform_2d_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pat2d_pkg::*;

    localparam int     COORD_W   = COORD_BITS_DEF;
    localparam int     SCALE_FR  = SCALE_FRAC_BITS_DEF;
    localparam int     TRIG_FR   = TRIG_FRAC_BITS_DEF;
    localparam int     DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // Sine table series: 30 fraction bits, pi at that scale
    localparam int          SERIES_FR = 30;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;

    // Register indexes past the last one, which the block must ignore
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

    localparam int N_PHASES       = 12;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      sat;
    } t_vertex;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [8:0]         angle;
    } t_setting;

    typedef struct packed {
        t_setting                  cfg;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      pinned;
        t_vertex                   want;
    } t_row;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data    = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [DATA_W-1:0]        s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [DATA_W-1:0]        m_axis_tdata;
    logic                     m_axis_tuser;

    longint   sine_q14 [0:QUARTER_DEG];
    t_setting cfg_now;
    t_vertex  expected_vertices [$];
    t_row     directed_rows [$];
    int       mismatch_count = 0;
    int       burst_left     = 0;

    point_affine_transform_2d_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // x_in, y_in
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // x_out, y_out
        .m_axis_tuser  (m_axis_tuser)    // saturated
    );

    // Run the clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Build the quarter-wave sine table with an integer Taylor series
    task automatic fill_sine_table();
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] term;
        logic [63:0] dd;
        logic [63:0] div;
        longint      acc;
        for (int d = 0; d <= QUARTER_DEG; d++) begin
            dd   = 64'(d);
            r    = (dd * PI_Q30 + 64'd90) / 64'd180;
            r2   = (r * r) >> SERIES_FR;
            term = r;
            acc  = longint'(r);
            for (int n = 1; n <= 8; n++) begin
                div  = 64'((2 * n) * (2 * n + 1));
                term = ((term * r2) >> SERIES_FR) / div;
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            sine_q14[d] = (acc + (longint'(1) << (SERIES_FR - TRIG_FR - 1)))
                          >> (SERIES_FR - TRIG_FR);
        end
    endtask

    // Round to nearest integer, ties away from zero
    function automatic longint round_away(input longint v, input int sh);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q   = (mag + (longint'(1) << (sh - 1))) >> sh;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return COORD_W'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            return COORD_W'(COORD_MIN);
        end
        return COORD_W'(v);
    endfunction

    // Predict one transformed vertex under the current register values
    function automatic t_vertex transform_vertex(input logic signed [COORD_W-1:0] xi,
                                                 input logic signed [COORD_W-1:0] yi);
        longint  x;
        longint  y;
        longint  xr;
        longint  yr;
        longint  sn;
        longint  cs;
        longint  lo;
        longint  hi;
        int      a;
        t_vertex v;
        x  = xi;
        y  = yi;
        xr = x;
        yr = y;
        case (cfg_now.mode)
            MODE_TRANSLATE: begin
                xr = x + longint'(cfg_now.shift_x);
                yr = y + longint'(cfg_now.shift_y);
            end
            MODE_SCALE: begin
                xr = round_away(x * longint'(cfg_now.scale_x), SCALE_FR);
                yr = round_away(y * longint'(cfg_now.scale_y), SCALE_FR);
            end
            MODE_ROTATE: begin
                a = int'(cfg_now.angle);
                if (a >= 360) begin
                    a = a - 360;
                end
                lo = sine_q14[a % QUARTER_DEG];
                hi = sine_q14[QUARTER_DEG - (a % QUARTER_DEG)];
                case (t_quad'(a / QUARTER_DEG))
                    QUAD_0:  begin sn = lo;  cs = hi;  end
                    QUAD_1:  begin sn = hi;  cs = -lo; end
                    QUAD_2:  begin sn = -lo; cs = -hi; end
                    default: begin sn = -hi; cs = lo;  end
                endcase
                xr = round_away(x * cs - y * sn, TRIG_FR);
                yr = round_away(x * sn + y * cs, TRIG_FR);
            end
            default: ;
        endcase
        v.x   = clamp_coord(xr);
        v.y   = clamp_coord(yr);
        v.sat = (xr > COORD_MAX) || (xr < COORD_MIN) || (yr > COORD_MAX) || (yr < COORD_MIN);
        return v;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // Write one register at the next edge and track it
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:    cfg_now.mode    = t_mode'(data[1:0]);
            CFG_SHIFT_X: cfg_now.shift_x = data;
            CFG_SHIFT_Y: cfg_now.shift_y = data;
            CFG_SCALE_X: cfg_now.scale_x = data;
            CFG_SCALE_Y: cfg_now.scale_y = data;
            CFG_ANGLE:   cfg_now.angle   = data[8:0];
            default: ;
        endcase
    endtask

    // Load a full setting; junk goes into the unused upper bits and a spare index
    task automatic apply_setting(input t_setting st);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_MODE, {junk[13:0], st.mode});
        write_reg(CFG_SHIFT_X, st.shift_x);
        write_reg(CFG_SHIFT_Y, st.shift_y);
        write_reg(CFG_SCALE_X, st.scale_x);
        write_reg(CFG_SCALE_Y, st.scale_y);
        write_reg(CFG_ANGLE, {junk[22:16], st.angle});
        write_reg(junk[31] ? IDX_SPARE_HI : IDX_SPARE_LO, CFG_DATA_BITS'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one vertex and hold it until the transfer
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic pinned, input t_vertex want);
        s_axis_tdata  <= {y, x};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_vertices.push_back(pinned ? want : transform_vertex(x, y));
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= DATA_W'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every pending result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_vertices.size() != 0);
        @(posedge i_clk);
    endtask

    // Extremes, a wide random value or a value near zero
    function automatic logic [15:0] pick_field(input int narrow);
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) begin
            case ($urandom_range(0, 5))
                0:       return 16'h8000;
                1:       return 16'h8001;
                2:       return 16'hffff;
                3:       return 16'h0000;
                4:       return 16'h0001;
                default: return 16'h7fff;
            endcase
        end
        if (r < 4) begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(0, 2 * narrow)) - narrow);
    endfunction

    function automatic t_setting make_setting(input t_mode m, input int shx, input int shy,
                                              input int scx, input int scy, input int ang);
        t_setting st;
        st.mode    = m;
        st.shift_x = shx[15:0];
        st.shift_y = shy[15:0];
        st.scale_x = scx[15:0];
        st.scale_y = scy[15:0];
        st.angle   = ang[8:0];
        return st;
    endfunction

    task automatic add_row(input t_setting st, input int x, input int y,
                           input logic pinned, input int ex, input int ey, input logic es);
        t_row row;
        row.cfg      = st;
        row.x        = x[COORD_W-1:0];
        row.y        = y[COORD_W-1:0];
        row.pinned   = pinned;
        row.want.x   = ex[COORD_W-1:0];
        row.want.y   = ey[COORD_W-1:0];
        row.want.sat = es;
        directed_rows.push_back(row);
    endtask

    // Receiver: ready, mostly ready, mostly stalled, and a long hold-off now and then
    initial begin : rx_pattern
        int   seg_no;
        int   kind;
        int   seg_len;
        logic rdy;
        seg_no = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (seg_no % 8 == 3) begin
                kind    = 3;
                seg_len = $urandom_range(40, 120);
            end else begin
                kind    = $urandom_range(0, 2);
                seg_len = $urandom_range(4, 40);
            end
            for (int k = 0; k < seg_len; k++) begin
                case (kind)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = 1'b0;
                endcase
                m_axis_tready <= rdy;
                @(posedge i_clk);
            end
            seg_no++;
        end
    end

    // Compare each result transfer with the oldest pending vertex
    always @(posedge i_clk) begin : result_check
        t_vertex got;
        t_vertex want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x   = m_axis_tdata[COORD_W-1:0];
            got.y   = m_axis_tdata[2*COORD_W-1:COORD_W];
            got.sat = m_axis_tuser;
            if (expected_vertices.size() == 0) begin
                note_mismatch("unexpected result, x_out", 0, longint'(got.x));
            end else begin
                want = expected_vertices.pop_front();
                if (got.x != want.x) begin
                    note_mismatch("x_out", longint'(want.x), longint'(got.x));
                end
                if (got.y != want.y) begin
                    note_mismatch("y_out", longint'(want.y), longint'(got.y));
                end
                if (got.sat != want.sat) begin
                    note_mismatch("saturated", longint'(want.sat), longint'(got.sat));
                end
            end
        end
    end

    initial begin : stimulus
        t_setting st_reset;
        t_setting st;
        t_vertex  none;
        t_row     row;
        int       gap;

        fill_sine_table();
        st_reset = make_setting(MODE_TRANSLATE, 0, 0, 256, 256, 0);
        cfg_now  = st_reset;
        none     = '0;

        // Directed table: config, x, y, pinned, expected x, y, saturated
        add_row(st_reset, 32767, -32768, 1, 32767, -32768, 0);
        add_row(st_reset, 0, 0, 1, 0, 0, 0);
        add_row(st_reset, -1, 1, 1, -1, 1, 0);
        st = make_setting(MODE_TRANSLATE, 1, -1, 256, 256, 0);
        add_row(st, 32767, -32768, 1, 32767, -32768, 1);
        st = make_setting(MODE_TRANSLATE, 32767, 32767, 256, 256, 0);
        add_row(st, 32767, -32768, 1, 32767, -1, 1);
        st = make_setting(MODE_TRANSLATE, -32768, -32768, 256, 256, 0);
        add_row(st, -32768, 32767, 1, -32768, -1, 1);
        add_row(st, 100, -100, 1, -32668, -32768, 1);
        st = make_setting(MODE_SCALE, 0, 0, -32768, -32768, 0);
        add_row(st, 1, -1, 1, -128, 128, 0);
        add_row(st, -32768, 32767, 0, 0, 0, 0);
        st = make_setting(MODE_SCALE, 0, 0, 32767, 32767, 0);
        add_row(st, 32767, -32768, 0, 0, 0, 0);
        // Half-way products round away from zero
        st = make_setting(MODE_SCALE, 0, 0, 128, -128, 0);
        add_row(st, 1, 1, 1, 1, -1, 0);
        add_row(st, 3, -3, 1, 2, 2, 0);
        add_row(st, -1, -1, 1, -1, 1, 0);
        st = make_setting(MODE_SCALE, 0, 0, 0, 0, 0);
        add_row(st, 12345, -4321, 1, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 0), 1000, -2000, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 90), 32767, -32768, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 180), -32768, -32768, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 270), 12345, -6789, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 359), 32767, 32767, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 45), 32767, 32767, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 1), -32768, 0, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 89), 0, 32767, 0, 0, 0, 0);
        // Angles past 359 wrap modulo 360
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 360), 5000, 7000, 0, 0, 0, 0);
        add_row(make_setting(MODE_ROTATE, 0, 0, 256, 256, 511), -20000, 15000, 0, 0, 0, 0);
        // Unused mode passes the vertex through
        st = make_setting(MODE_PASS, 77, -77, 512, 512, 33);
        add_row(st, -32768, 32767, 1, -32768, 32767, 0);
        add_row(st, 12345, -1, 1, 12345, -1, 0);

        // Hold reset, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table, reloading registers only when idle
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.cfg != cfg_now) begin
                drain();
                apply_setting(row.cfg);
            end
            send_vertex(row.x, row.y, row.pinned, row.want);
            if ($urandom_range(0, 2) == 0) begin
                pause_sender($urandom_range(1, 5));
            end
        end

        // Random phases, each under a fresh setting
        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain();
            st.mode    = (phase < 9) ? t_mode'(phase % 3) : t_mode'($urandom_range(0, 3));
            st.shift_x = pick_field(400);
            st.shift_y = pick_field(400);
            st.scale_x = pick_field(768);
            st.scale_y = pick_field(768);
            st.angle   = 9'($urandom_range(0, 511));
            apply_setting(st);
            burst_left = $urandom_range(1, 24);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_vertex(pick_field(2000), pick_field(2000), 1'b0, none);
                // Pause mid-phase until the pipeline is empty
                if (phase == 4 && k == ITEMS_PER_PHASE / 2) begin
                    drain();
                end else if (burst_left == 0) begin
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 3);
                    pause_sender(gap);
                    burst_left = $urandom_range(1, 24);
                end else begin
                    burst_left--;
                end
            end
        end

        // Flush and allow any stray results to show up
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/pat2d_pkg.sv
hdl/point_affine_transform_2d_top.sv
tb/sv/tb_point_affine_transform_2d_top.sv
